// ----- hdl/mwam_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mwam_pkg
// Shared types and constants for the clipped-window abs mean / max unit.
// ----------------------------------------------------------------------------
package mwam_pkg;

  localparam int VAL_W    = 16;
  localparam int RC_W     = 6;
  localparam int SIZE_W   = 7;
  localparam int HALF_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic MODE_MEAN = 1'b0;
  localparam logic MODE_MAX  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RST = 7'd64;
  localparam logic [HALF_W-1:0] HALF_RST = 3'd1;
  localparam logic              MODE_RST = MODE_MEAN;

  // controller -> datapath
  typedef struct packed {
    logic mem_wr;    // write request accepted
    logic load;      // query request accepted
    logic bounds;    // latch clipped window bounds
    logic walk;      // issue one window read
    logic div_init;
    logic div_step;
    logic out_load;
  } mwam_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic oob;
    logic is_mean;
    logic walk_last;
    logic div_last;
    logic out_free;
  } mwam_status_t;

endpackage : mwam_pkg
`default_nettype wire

// ----- hdl/mwam_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mwam_ctrl
// Sequencer: accepts requests, steps the window walk, the divider and the
// output load.
// ----------------------------------------------------------------------------
module mwam_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire                    req_type,
  input  mwam_pkg::mwam_status_t status,
  output mwam_pkg::mwam_cmd_t    cmd
);
  import mwam_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_WALK,
    S_DRAIN,
    S_DIV_INIT,
    S_DIV,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (req_type == REQ_QUERY) begin
            cmd.load   = 1'b1;
            state_next = S_SETUP;
          end else begin
            cmd.mem_wr = 1'b1;
          end
        end
      end
      S_SETUP: begin
        cmd.bounds = 1'b1;
        state_next = status.oob ? S_FINISH : S_WALK;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (status.walk_last) state_next = S_DRAIN;
      end
      // last read word is folded into the accumulator here
      S_DRAIN: begin
        state_next = status.is_mean ? S_DIV_INIT : S_FINISH;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule : mwam_ctrl
`default_nettype wire

// ----- hdl/mwam_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mwam_datapath
// Matrix memory, config registers, window walk counters, accumulator,
// restoring divider and output register.
// ----------------------------------------------------------------------------
module mwam_datapath #(
  parameter int P_MAX = 64,
  parameter int H_MAX = 7
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_valid,
  input  wire  [mwam_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [mwam_pkg::CFG_DAT_W-1:0]      cfg_data,
  input  wire  [mwam_pkg::RC_W-1:0]           row,
  input  wire  [mwam_pkg::RC_W-1:0]           col,
  input  wire  signed [mwam_pkg::VAL_W-1:0]   element_value,
  input  mwam_pkg::mwam_cmd_t                 cmd,
  output mwam_pkg::mwam_status_t              status,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [mwam_pkg::VAL_W-1:0]          result_value
);
  import mwam_pkg::*;

  localparam int IW    = (P_MAX > 1) ? $clog2(P_MAX) : 1;
  localparam int PW    = $clog2(P_MAX + 1);
  localparam int HW    = $clog2(H_MAX + 1);
  localparam int DEPTH = P_MAX * P_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int WIN   = 2 * H_MAX + 1;
  localparam int CNTW  = $clog2(WIN * WIN + 1);
  localparam int SW    = VAL_W + CNTW;
  localparam int DCW   = $clog2(SW);
  localparam int EW    = ((IW > HW) ? IW : HW) + 1;
  localparam int MW    = (PW > SIZE_W) ? PW : SIZE_W;
  localparam int CMPW  = (PW > RC_W) ? PW : RC_W;
  localparam int HCW   = (HW > HALF_W) ? HW : HALF_W;

  // config registers
  logic [SIZE_W-1:0] size_reg;
  logic [HALF_W-1:0] half_reg;
  logic              mode_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= SIZE_RST;
      half_reg <= HALF_RST;
      mode_reg <= MODE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SIZE: size_reg <= cfg_data[SIZE_W-1:0];
        CFG_HALF: half_reg <= cfg_data[HALF_W-1:0];
        CFG_MODE: mode_reg <= cfg_data[0];
        default:  ;
      endcase
    end
  end

  // effective size and half-width
  logic [PW-1:0] p_eff;
  logic [HW-1:0] h_eff;
  logic          in_range;
  logic [IW-1:0] row_idx;
  logic [IW-1:0] col_idx;
  logic [AW-1:0] wr_addr;

  always_comb begin
    if (size_reg == '0) begin
      p_eff = PW'(1);
    end else if (MW'(size_reg) > MW'(P_MAX)) begin
      p_eff = PW'(P_MAX);
    end else begin
      p_eff = PW'(size_reg);
    end
    h_eff    = (HCW'(half_reg) > HCW'(H_MAX)) ? HW'(H_MAX) : HW'(half_reg);
    in_range = (CMPW'(row) < CMPW'(p_eff)) && (CMPW'(col) < CMPW'(p_eff));
    row_idx  = IW'(row);
    col_idx  = IW'(col);
    wr_addr  = AW'(row_idx) * AW'(P_MAX) + AW'(col_idx);
  end

  // query context
  logic [IW-1:0] r_q;
  logic [IW-1:0] c_q;
  logic [PW-1:0] p_q;
  logic [HW-1:0] h_q;
  logic          mode_q;
  logic          oob_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_q    <= row_idx;
      c_q    <= col_idx;
      p_q    <= p_eff;
      h_q    <= h_eff;
      mode_q <= mode_reg;
      oob_q  <= !in_range;
    end
  end

  // clipped bounds
  logic [EW-1:0]   r_e, c_e, h_e, pm1_e;
  logic [EW-1:0]   rl_e, rh_e, cl_e, ch_e;
  logic [EW-1:0]   nrows_e, ncols_e;
  logic [CNTW-1:0] cnt_calc;

  always_comb begin
    r_e     = EW'(r_q);
    c_e     = EW'(c_q);
    h_e     = EW'(h_q);
    pm1_e   = EW'(p_q) - EW'(1);
    rl_e    = (r_e > h_e) ? r_e - h_e : '0;
    cl_e    = (c_e > h_e) ? c_e - h_e : '0;
    rh_e    = (r_e + h_e < pm1_e) ? r_e + h_e : pm1_e;
    ch_e    = (c_e + h_e < pm1_e) ? c_e + h_e : pm1_e;
    nrows_e = rh_e - rl_e + EW'(1);
    ncols_e = ch_e - cl_e + EW'(1);
    cnt_calc = CNTW'(CNTW'(nrows_e) * CNTW'(ncols_e));
  end

  logic [IW-1:0]   cl_q, rh_q, ch_q;
  logic [CNTW-1:0] cnt_q;
  logic [IW-1:0]   i_q, j_q;
  logic            walk_last;

  assign walk_last = (i_q == rh_q) && (j_q == ch_q);

  always_ff @(posedge clk) begin
    if (cmd.bounds) begin
      cl_q  <= IW'(cl_e);
      rh_q  <= IW'(rh_e);
      ch_q  <= IW'(ch_e);
      cnt_q <= cnt_calc;
      i_q   <= IW'(rl_e);
      j_q   <= IW'(cl_e);
    end else if (cmd.walk) begin
      if (j_q == ch_q) begin
        j_q <= cl_q;
        i_q <= i_q + IW'(1);
      end else begin
        j_q <= j_q + IW'(1);
      end
    end
  end

  // matrix memory, registered read
  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_data;
  logic             rd_vld;
  logic [AW-1:0]    rd_addr;

  assign rd_addr = AW'(i_q) * AW'(P_MAX) + AW'(j_q);

  always_ff @(posedge clk) begin
    if (cmd.mem_wr && in_range) begin
      mem[wr_addr] <= element_value;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.walk;
    end
  end

  // |x| into acc: summed in mean mode, maximum kept in max mode; -32768 maps to 32768 as unsigned
  logic [VAL_W-1:0] abs_val;
  logic [SW-1:0]    acc;

  assign abs_val = rd_data[VAL_W-1] ? VAL_W'(-rd_data) : rd_data;

  always_ff @(posedge clk) begin
    if (cmd.bounds) begin
      acc <= '0;
    end else if (rd_vld) begin
      if (mode_q == MODE_MEAN) begin
        acc <= acc + SW'(abs_val);
      end else if (SW'(abs_val) > acc) begin
        acc <= SW'(abs_val);
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [CNTW-1:0] rem;
  logic [SW-1:0]   dq;
  logic [DCW-1:0]  div_cnt;
  logic [CNTW:0]   shifted;
  logic            ge;

  assign shifted = {rem, dq[SW-1]};
  assign ge      = (shifted >= {1'b0, cnt_q});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem     <= '0;
      dq      <= acc;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= ge ? CNTW'(shifted - {1'b0, cnt_q}) : CNTW'(shifted);
      dq      <= {dq[SW-2:0], ge};
      div_cnt <= div_cnt + DCW'(1);
    end
  end

  // output register
  logic [VAL_W-1:0] res_sel;

  always_comb begin
    if (oob_q) begin
      res_sel = '0;
    end else if (mode_q == MODE_MAX) begin
      res_sel = acc[VAL_W-1:0];
    end else begin
      res_sel = dq[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_value <= res_sel;
    end
  end

  assign status.oob       = oob_q;
  assign status.is_mean   = (mode_q == MODE_MEAN);
  assign status.walk_last = walk_last;
  assign status.div_last  = (div_cnt == DCW'(SW - 1));
  assign status.out_free  = !out_valid || out_ready;

endmodule : mwam_datapath
`default_nettype wire

// ----- hdl/matrix_window_abs_mean_max_unit.sv -----
`default_nettype none
// Write request: accepted back to back.
// Query: accept, setup, one window read per element (up to 225), drain,
//   then in mean mode divider init and the divider steps, then the result load; the query time
//   is set by the single read port of the matrix memory and the bit-serial divider.
// Out-of-range query: accept, setup, result load. Result register frees the input side.
// rst (synchronous) clears control and config; matrix contents are not cleared.
// ----------------------------------------------------------------------------
// matrix_window_abs_mean_max_unit
// Clipped square-window mean or maximum of absolute values over a stored
// signed 16-bit matrix.
// ----------------------------------------------------------------------------
module matrix_window_abs_mean_max_unit #(
  parameter int P_MAX = 64,
  parameter int H_MAX = 7
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [mwam_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [mwam_pkg::CFG_DAT_W-1:0]      cfg_data,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire                                 req_type,
  input  wire  [mwam_pkg::RC_W-1:0]           row,
  input  wire  [mwam_pkg::RC_W-1:0]           col,
  input  wire  signed [mwam_pkg::VAL_W-1:0]   element_value,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [mwam_pkg::VAL_W-1:0]          result_value
);
  import mwam_pkg::*;

  mwam_cmd_t    cmd;
  mwam_status_t status;

  assign cfg_ready = 1'b1;

  mwam_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .status   (status),
    .cmd      (cmd)
  );

  mwam_datapath #(
    .P_MAX (P_MAX),
    .H_MAX (H_MAX)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .row           (row),
    .col           (col),
    .element_value (element_value),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_value  (result_value)
  );

endmodule : matrix_window_abs_mean_max_unit
`default_nettype wire

// ----- dv/matrix_window_abs_mean_max_unit_tb.sv -----
// ----------------------------------------------------------------------------
// matrix_window_abs_mean_max_unit_tb
// Self-checking bench for the clipped-window abs mean / max unit. A directed
// table hits the edges of the value range, window clipping, mean truncation,
// out-of-range writes and queries, and both ends of every register. Random
// phases follow, each with its own register setting. Every query result is
// checked against the table's value or a shadow matrix and window predictor.
// Before a query, any unwritten entry in its window gets a write first.
// ----------------------------------------------------------------------------
module matrix_window_abs_mean_max_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mwam_pkg::*;

  localparam int     CLK_PERIOD     = 12;
  localparam int     P_MAX          = 64;
  localparam int     ITEM_TARGET    = 1450;
  localparam int     PHASE_ITEMS    = 100;
  localparam int     SETTLE_CYCLES  = 8;
  localparam int     DRAIN_CYCLES   = 300;
  localparam int     LONG_HOLD      = 700;
  localparam longint TIMEOUT_CYCLES = 3_000_000;

  typedef enum logic [1:0] {STEP_CFG, STEP_WRITE, STEP_QUERY} step_kind_t;

  typedef struct packed {
    step_kind_t           kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [RC_W-1:0]      row;
    logic [RC_W-1:0]      col;
    logic [VAL_W-1:0]     data;
    logic                 known;
    logic [VAL_W-1:0]     known_res;
  } dir_step_t;

  localparam int DIR_STEPS = 35;

  localparam dir_step_t DIRECTED [DIR_STEPS] = '{
    '{STEP_CFG,   CFG_SIZE, 6'd0,  6'd0,  16'd1,     1'b0, 16'd0},
    '{STEP_CFG,   CFG_MODE, 6'd0,  6'd0,  16'd1,     1'b0, 16'd0},
    '{STEP_WRITE, CFG_SIZE, 6'd0,  6'd0,  16'h8000,  1'b0, 16'd0},
    '{STEP_QUERY, CFG_SIZE, 6'd0,  6'd0,  16'd0,     1'b1, 16'd32768},
    '{STEP_QUERY, CFG_SIZE, 6'd1,  6'd0,  16'd0,     1'b1, 16'd0},
    '{STEP_QUERY, CFG_SIZE, 6'd0,  6'd63, 16'd0,     1'b1, 16'd0},
    '{STEP_WRITE, CFG_SIZE, 6'd3,  6'd3,  16'd1234,  1'b0, 16'd0},
    '{STEP_QUERY, CFG_SIZE, 6'd63, 6'd63, 16'd0,     1'b1, 16'd0},
    '{STEP_CFG,   CFG_MODE, 6'd0,  6'd0,  16'd0,     1'b0, 16'd0},
    '{STEP_QUERY, CFG_SIZE, 6'd0,  6'd0,  16'd0,     1'b1, 16'd32768},
    '{STEP_WRITE, CFG_SIZE, 6'd0,  6'd0,  16'h7FFF,  1'b0, 16'd0},
    '{STEP_QUERY, CFG_SIZE, 6'd0,  6'd0,  16'd0,     1'b1, 16'd32767},
    '{STEP_CFG,   CFG_SIZE, 6'd0,  6'd0,  16'd0,     1'b0, 16'd0},
    '{STEP_QUERY, CFG_SIZE, 6'd0,  6'd0,  16'd0,     1'b1, 16'd32767},
    '{STEP_QUERY, CFG_SIZE, 6'd0,  6'd1,  16'd0,     1'b1, 16'd0},
    '{STEP_CFG,   CFG_SIZE, 6'd0,  6'd0,  16'd2,     1'b0, 16'd0},
    '{STEP_CFG,   CFG_HALF, 6'd0,  6'd0,  16'd7,     1'b0, 16'd0},
    '{STEP_WRITE, CFG_SIZE, 6'd0,  6'd1,  16'h8000,  1'b0, 16'd0},
    '{STEP_WRITE, CFG_SIZE, 6'd1,  6'd0,  16'h8000,  1'b0, 16'd0},
    '{STEP_WRITE, CFG_SIZE, 6'd1,  6'd1,  16'h8000,  1'b0, 16'd0},
    // 32767 + 3 * 32768 over 4: quotient truncates
    '{STEP_QUERY, CFG_SIZE, 6'd1,  6'd1,  16'd0,     1'b1, 16'd32767},
    '{STEP_WRITE, CFG_SIZE, 6'd0,  6'd0,  16'h8000,  1'b0, 16'd0},
    '{STEP_QUERY, CFG_SIZE, 6'd0,  6'd0,  16'd0,     1'b1, 16'd32768},
    '{STEP_CFG,   CFG_MODE, 6'd0,  6'd0,  16'd1,     1'b0, 16'd0},
    '{STEP_QUERY, CFG_SIZE, 6'd0,  6'd1,  16'd0,     1'b1, 16'd32768},
    '{STEP_CFG,   CFG_SIZE, 6'd0,  6'd0,  16'd127,   1'b0, 16'd0},
    '{STEP_CFG,   CFG_HALF, 6'd0,  6'd0,  16'd0,     1'b0, 16'd0},
    '{STEP_WRITE, CFG_SIZE, 6'd63, 6'd63, 16'hFFFF,  1'b0, 16'd0},
    '{STEP_QUERY, CFG_SIZE, 6'd63, 6'd63, 16'd0,     1'b1, 16'd1},
    '{STEP_WRITE, CFG_SIZE, 6'd63, 6'd0,  16'h8001,  1'b0, 16'd0},
    '{STEP_QUERY, CFG_SIZE, 6'd63, 6'd0,  16'd0,     1'b1, 16'd32767},
    '{STEP_QUERY, CFG_SIZE, 6'd0,  6'd0,  16'd0,     1'b1, 16'd32768},
    '{STEP_CFG,   CFG_HALF, 6'd0,  6'd0,  16'd1,     1'b0, 16'd0},
    '{STEP_CFG,   CFG_MODE, 6'd0,  6'd0,  16'd0,     1'b0, 16'd0},
    '{STEP_QUERY, CFG_SIZE, 6'd0,  6'd0,  16'd0,     1'b0, 16'd0}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 req_type = REQ_WRITE;
  logic [RC_W-1:0]      row = '0;
  logic [RC_W-1:0]      col = '0;
  logic signed [VAL_W-1:0] element_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [VAL_W-1:0]     result_value;

  matrix_window_abs_mean_max_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .row           (row),
    .col           (col),
    .element_value (element_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_value  (result_value)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // shadow of the matrix and the registers
  logic [VAL_W-1:0]  mat_shadow [P_MAX * P_MAX];
  bit                mat_written [P_MAX * P_MAX];
  logic [SIZE_W-1:0] cfg_size = SIZE_RST;
  logic [HALF_W-1:0] cfg_half = HALF_RST;
  logic              cfg_mode = MODE_RST;

  logic [VAL_W-1:0]  pending_results [$];
  int                errors = 0;
  int                accepted_items = 0;
  bit                in_calm = 1'b0;
  bit                out_calm = 1'b0;

  function automatic int eff_size();
    if (cfg_size == 0) return 1;
    if (cfg_size > P_MAX) return P_MAX;
    return int'(cfg_size);
  endfunction

  function automatic void window_bounds(input int r, input int c,
                                        output int rl, output int rh,
                                        output int cl, output int ch);
    int p;
    int h;
    p  = eff_size();
    h  = int'(cfg_half);
    rl = (r > h) ? r - h : 0;
    rh = (r + h < p - 1) ? r + h : p - 1;
    cl = (c > h) ? c - h : 0;
    ch = (c + h < p - 1) ? c + h : p - 1;
  endfunction

  function automatic logic [VAL_W-1:0] window_abs_result(input logic [RC_W-1:0] r,
                                                         input logic [RC_W-1:0] c);
    int rl, rh, cl, ch;
    int acc;
    int mag;
    logic [VAL_W-1:0] raw;
    if (r >= eff_size() || c >= eff_size()) return '0;
    window_bounds(int'(r), int'(c), rl, rh, cl, ch);
    acc = 0;
    for (int i = rl; i <= rh; i++) begin
      for (int j = cl; j <= ch; j++) begin
        raw = mat_shadow[i * P_MAX + j];
        mag = raw[VAL_W-1] ? 65536 - int'(raw) : int'(raw);
        if (cfg_mode == MODE_MEAN) acc += mag;
        else if (mag > acc) acc = mag;
      end
    end
    if (cfg_mode == MODE_MEAN) acc = acc / ((rh - rl + 1) * (ch - cl + 1));
    return acc[VAL_W-1:0];
  endfunction

  // Leaves in_valid high after the accepting edge; the next request or the
  // caller lowers it.
  task automatic send_req(input logic rtype, input logic [RC_W-1:0] r,
                          input logic [RC_W-1:0] c, input logic [VAL_W-1:0] v,
                          input bit known, input logic [VAL_W-1:0] known_res);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= rtype;
    row           <= r;
    col           <= c;
    element_value <= v;
    do @(posedge clk); while (!in_ready);
    if (rtype == REQ_QUERY) begin
      pending_results.push_back(known ? known_res : window_abs_result(r, c));
      accepted_items++;
    end else if (r < eff_size() && c < eff_size()) begin
      mat_shadow[int'(r) * P_MAX + int'(c)]  = v;
      mat_written[int'(r) * P_MAX + int'(c)] = 1'b1;
      accepted_items++;
    end
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] dat);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= dat;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SIZE: cfg_size = dat[SIZE_W-1:0];
      CFG_HALF: cfg_half = dat[HALF_W-1:0];
      CFG_MODE: cfg_mode = dat[0];
      default: ;
    endcase
  endtask

  // Registers change only with the unit idle: all results back, writes retired.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] random_value();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Never let a query read an entry that was never written.
  task automatic fill_window(input logic [RC_W-1:0] r, input logic [RC_W-1:0] c);
    int rl, rh, cl, ch;
    if (r >= eff_size() || c >= eff_size()) return;
    window_bounds(int'(r), int'(c), rl, rh, cl, ch);
    for (int i = rl; i <= rh; i++) begin
      for (int j = cl; j <= ch; j++) begin
        if (!mat_written[i * P_MAX + j])
          send_req(REQ_WRITE, RC_W'(i), RC_W'(j), random_value(), 1'b0, '0);
      end
    end
  endtask

  task automatic random_item();
    int p;
    logic [RC_W-1:0] r;
    logic [RC_W-1:0] c;
    p = eff_size();
    if ($urandom_range(0, 9) == 0) begin
      r = RC_W'($urandom);
      c = RC_W'($urandom);
    end else begin
      r = RC_W'($urandom_range(0, p - 1));
      c = RC_W'($urandom_range(0, p - 1));
    end
    if ($urandom_range(0, 99) < 45) begin
      fill_window(r, c);
      send_req(REQ_QUERY, r, c, random_value(), 1'b0, '0);
    end else begin
      send_req(REQ_WRITE, r, c, random_value(), 1'b0, '0);
    end
  endtask

  task automatic random_config();
    int pick;
    logic [CFG_DAT_W-1:0] size_dat;
    logic [CFG_DAT_W-1:0] half_dat;
    pick = $urandom_range(0, 19);
    // large sizes are slow, so most phases stay small
    if (pick == 0) size_dat = 7'd64;
    else if (pick == 1) size_dat = 7'd0;
    else if (pick == 2) size_dat = CFG_DAT_W'($urandom_range(65, 127));
    else size_dat = CFG_DAT_W'($urandom_range(1, 12));
    // big matrices keep the window small so window fills stay short
    if (size_dat > 7'd12) half_dat = CFG_DAT_W'($urandom_range(0, 1));
    else half_dat = CFG_DAT_W'($urandom_range(0, 127));
    settle();
    cfg_write(CFG_SIZE, size_dat);
    cfg_write(CFG_HALF, half_dat);
    cfg_write(CFG_MODE, CFG_DAT_W'($urandom_range(0, 127)));
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    bit prev_cfg;
    prev_cfg = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < DIR_STEPS; k++) begin
      case (DIRECTED[k].kind)
        STEP_CFG: begin
          if (!prev_cfg) settle();
          cfg_write(DIRECTED[k].reg_idx, DIRECTED[k].data[CFG_DAT_W-1:0]);
          if (k + 1 == DIR_STEPS || DIRECTED[k + 1].kind != STEP_CFG) cfg_valid <= 1'b0;
        end
        STEP_WRITE: send_req(REQ_WRITE, DIRECTED[k].row, DIRECTED[k].col,
                             DIRECTED[k].data, 1'b0, '0);
        default:    send_req(REQ_QUERY, DIRECTED[k].row, DIRECTED[k].col,
                             DIRECTED[k].data, DIRECTED[k].known, DIRECTED[k].known_res);
      endcase
      prev_cfg = (DIRECTED[k].kind == STEP_CFG);
    end

    while (accepted_items < ITEM_TARGET) begin
      random_config();
      in_calm = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS && accepted_items < ITEM_TARGET; n++) random_item();
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("matrix_window_abs_mean_max_unit_tb: done, clean");
    else
      $display("matrix_window_abs_mean_max_unit_tb: done, errors");
    $finish;
  end

  initial begin : result_sink
    int stall;
    int seen;
    logic [VAL_W-1:0] want;
    seen = 0;
    while (rst) @(posedge clk);
    forever begin
      if (seen % 64 == 0) out_calm = ($urandom_range(0, 3) == 0);
      // two long holds so the unit backs up into its input
      if (seen == 40 || seen == 400) stall = LONG_HOLD;
      else stall = out_calm ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        errors++;
        $display("%t: result_value %0d with no query pending", $time, result_value);
      end else begin
        want = pending_results.pop_front();
        if (result_value !== want) begin
          errors++;
          $display("%t: result_value mismatch: expected %0d, actual %0d",
                   $time, want, result_value);
        end
      end
      seen++;
    end
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("matrix_window_abs_mean_max_unit_tb: done, errors");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/mwam_pkg.sv
hdl/mwam_ctrl.sv
hdl/mwam_datapath.sv
hdl/matrix_window_abs_mean_max_unit.sv
dv/matrix_window_abs_mean_max_unit_tb.sv
